@@ src/sm4ce_pkg.sv @@
// ----------------------------------------------------------------------------
// sm4ce_pkg
// Shared constants, types and helper functions for the SM4 ECB/CBC cipher.
// ----------------------------------------------------------------------------
package sm4ce_pkg;

  localparam int unsigned ROUND_COUNT = 32;
  localparam int unsigned RND_W       = $clog2(ROUND_COUNT);

  // block size in bytes, also the pad count of an all-padding block
  localparam logic [4:0] BLOCK_BYTES = 5'd16;

  localparam logic [7:0]  CK_STEP  = 8'h07;
  localparam logic [63:0] PAD_FULL = 64'h1010_1010_1010_1010;

  localparam logic [31:0] FK0 = 32'ha3b1bac6;
  localparam logic [31:0] FK1 = 32'h56aa3350;
  localparam logic [31:0] FK2 = 32'h677d9197;
  localparam logic [31:0] FK3 = 32'hb27022dc;

  // configuration register indexes
  localparam logic [2:0] REG_KEY_HI = 3'd0;
  localparam logic [2:0] REG_KEY_LO = 3'd1;
  localparam logic [2:0] REG_IV_HI  = 3'd2;
  localparam logic [2:0] REG_IV_LO  = 3'd3;
  localparam logic [2:0] REG_CHAIN  = 3'd4;
  localparam logic [2:0] REG_DIR    = 3'd5;

  typedef enum logic {
    RM_CIPHER = 1'b0,
    RM_KEY    = 1'b1
  } rmode_e;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [31:0] sbox_word(logic [31:0] x);
    return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  // key schedule constant: byte j of word i is (4*i + j) * 7 mod 256
  function automatic logic [31:0] ck_word(logic [RND_W-1:0] idx);
    logic [7:0]  b;
    logic [31:0] w;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      b = 8'((8'({idx, 2'b00}) + 8'(j)) * CK_STEP);
      w = {w[23:0], b};
    end
    return w;
  endfunction

endpackage

@@ src/sm4ce_if.sv @@
// ----------------------------------------------------------------------------
// sm4ce_if
// Valid/ready channels for input blocks and result blocks.
// ----------------------------------------------------------------------------
interface sm4ce_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_high;
  logic [63:0] block_low;
  logic        first_block;
  logic        last_block;
  logic [4:0]  valid_bytes;

  modport source (
    output valid, block_high, block_low, first_block, last_block, valid_bytes,
    input  ready
  );
  modport sink (
    input  valid, block_high, block_low, first_block, last_block, valid_bytes,
    output ready
  );
endinterface

interface sm4ce_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_high;
  logic [63:0] out_low;
  logic        last_out;
  logic [7:0]  pad_count;

  modport source (
    output valid, out_high, out_low, last_out, pad_count,
    input  ready
  );
  modport sink (
    input  valid, out_high, out_low, last_out, pad_count,
    output ready
  );
endinterface

@@ src/sm4_cipher_ecb_cbc.sv @@
// ----------------------------------------------------------------------------
// sm4_cipher_ecb_cbc
// SM4 block cipher, ECB or CBC, PKCS#7 padding on encryption.
//
// Input blocks arrive on in_i and result blocks leave on out_o, both
// valid/ready; a transfer happens on a clock edge with valid and ready high.
// Key, IV, chaining mode and direction sit behind the APB port at 8*index.
// The round keys live in a 32-entry RAM with a registered read; one shared
// round unit fills it and later runs the data rounds.
// After reset, and after each write to a key register, the key schedule runs
// (a load, then one round key a cycle); in_i is not ready then.
// A block passes through the transfer cycle, 32 rounds at one RAM read and
// one round a cycle, and a writeback into the output register. A full last
// block being encrypted is followed by 32 more rounds and a writeback for the all-padding block.
// Results wait in the output register while the next block already runs its
// rounds; a stalled receiver holds the engine only at writeback.
// Reset clears the configuration and the chaining value to zero.
// ----------------------------------------------------------------------------
module sm4_cipher_ecb_cbc (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [5:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready,
  sm4ce_in_if.sink             in_i,
  sm4ce_out_if.source          out_o
);
  import sm4ce_pkg::*;

  typedef enum logic [4:0] {
    ST_KEYLD  = 5'b00001,
    ST_EXPAND = 5'b00010,
    ST_IDLE   = 5'b00100,
    ST_ROUND  = 5'b01000,
    ST_DONE   = 5'b10000
  } state_e;

  function automatic logic [127:0] pad_block(logic [127:0] blk, logic [4:0] nbytes);
    logic [7:0]   padv;
    logic [127:0] r;
    padv = 8'(BLOCK_BYTES - nbytes);
    for (int i = 0; i < 16; i++) begin
      r[127-8*i -: 8] = (5'(i) < nbytes) ? blk[127-8*i -: 8] : padv;
    end
    return r;
  endfunction

  // configuration
  logic [127:0] key_q, iv_q;
  logic         chain_mode_q, direction_q;
  logic         wr_en, key_wr;
  logic [2:0]   reg_idx;

  // engine
  state_e           state_q, state_d;
  logic [RND_W-1:0] cnt_q, cnt_d;
  logic [127:0]     x_q, x_d;
  logic [127:0]     chain_q, chain_d;
  logic [127:0]     hold_q, hold_d;
  logic             last_q, last_d;
  logic [4:0]       pad_q, pad_d;
  logic             extra_q, extra_d;

  // round key RAM
  logic [31:0]      rk_mem [ROUND_COUNT];
  logic [31:0]      rk_q;
  logic             rk_we;
  logic [RND_W-1:0] rk_raddr, rd_step;

  // round unit
  logic [31:0]  rk_sel, t_round;
  rmode_e       rmode;
  logic [127:0] x_shift;

  // output register
  logic         out_valid_q, out_valid_d;
  logic [127:0] out_blk_q, out_blk_d;
  logic         out_last_q, out_last_d;
  logic [7:0]   out_pad_q, out_pad_d;
  logic         out_free, out_load;

  // input side
  logic         in_fire;
  logic [127:0] in_blk, chain_sel, in_padded, res_blk;
  logic [4:0]   vbytes;
  logic         short_last;

  // ---------------------------------------------------------------- APB
  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel & penable & pwrite;
  assign key_wr  = wr_en && (reg_idx == REG_KEY_HI || reg_idx == REG_KEY_LO);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q        <= '0;
      iv_q         <= '0;
      chain_mode_q <= 1'b0;
      direction_q  <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_KEY_HI: key_q[127:64] <= pwdata;
        REG_KEY_LO: key_q[63:0]   <= pwdata;
        REG_IV_HI:  iv_q[127:64]  <= pwdata;
        REG_IV_LO:  iv_q[63:0]    <= pwdata;
        REG_CHAIN:  chain_mode_q  <= pwdata[0];
        REG_DIR:    direction_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_KEY_HI: prdata = key_q[127:64];
      REG_KEY_LO: prdata = key_q[63:0];
      REG_IV_HI:  prdata = iv_q[127:64];
      REG_IV_LO:  prdata = iv_q[63:0];
      REG_CHAIN:  prdata = {63'd0, chain_mode_q};
      REG_DIR:    prdata = {63'd0, direction_q};
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- key RAM
  // read the next round's key in advance through the registered read; decryption walks backwards
  assign rd_step  = (state_q == ST_ROUND) ? cnt_q + 1'b1 : '0;
  assign rk_raddr = direction_q ? ~rd_step : rd_step;
  assign rk_we    = (state_q == ST_EXPAND);

  always_ff @(posedge clk_i) begin
    if (rk_we) begin
      rk_mem[cnt_q] <= t_round;
    end
    rk_q <= rk_mem[rk_raddr];
  end

  // --------------------------------------------------------- round unit
  assign rmode   = (state_q == ST_EXPAND) ? RM_KEY : RM_CIPHER;
  assign rk_sel  = (state_q == ST_EXPAND) ? ck_word(cnt_q) : rk_q;
  assign x_shift = {x_q[95:0], t_round};

  sm4ce_round u_round (
    .x_i    (x_q),
    .rk_i   (rk_sel),
    .mode_i (rmode),
    .t_o    (t_round)
  );

  // ------------------------------------------------------------ control
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign in_blk     = {in_i.block_high, in_i.block_low};
  assign chain_sel  = in_i.first_block ? iv_q : chain_q;
  assign vbytes     = (in_i.valid_bytes > BLOCK_BYTES) ? BLOCK_BYTES : in_i.valid_bytes;
  assign short_last = in_i.last_block && (vbytes != BLOCK_BYTES);
  assign in_padded  = short_last ? pad_block(in_blk, vbytes) : in_blk;

  assign out_free = !out_valid_q || out_o.ready;
  assign res_blk  = (direction_q && chain_mode_q) ? (x_q ^ chain_q) : x_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    x_d        = x_q;
    chain_d    = chain_q;
    hold_d     = hold_q;
    last_d     = last_q;
    pad_d      = pad_q;
    extra_d    = extra_q;
    out_load   = 1'b0;
    out_blk_d  = out_blk_q;
    out_last_d = out_last_q;
    out_pad_d  = out_pad_q;

    unique case (state_q)
      ST_KEYLD: begin
        x_d     = key_q ^ {FK0, FK1, FK2, FK3};
        cnt_d   = '0;
        state_d = ST_EXPAND;
      end
      ST_EXPAND: begin
        x_d   = x_shift;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == RND_W'(ROUND_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          chain_d = chain_sel;
          cnt_d   = '0;
          state_d = ST_ROUND;
          if (direction_q) begin
            x_d     = in_blk;
            hold_d  = in_blk;
            last_d  = in_i.last_block;
            pad_d   = '0;
            extra_d = 1'b0;
          end else begin
            x_d     = chain_mode_q ? (in_padded ^ chain_sel) : in_padded;
            last_d  = short_last;
            pad_d   = short_last ? BLOCK_BYTES - vbytes : '0;
            extra_d = in_i.last_block && !short_last;
          end
        end
      end
      ST_ROUND: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == RND_W'(ROUND_COUNT - 1)) begin
          // final word order is reversed
          x_d     = {x_shift[31:0], x_shift[63:32], x_shift[95:64], x_shift[127:96]};
          state_d = ST_DONE;
        end else begin
          x_d = x_shift;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_blk_d  = res_blk;
          out_last_d = last_q;
          if (direction_q) begin
            chain_d   = hold_q;
            out_pad_d = last_q ? res_blk[7:0] : '0;
          end else begin
            chain_d   = x_q;
            out_pad_d = {3'd0, pad_q};
          end
          if (extra_q) begin
            // full last block: follow with an all-padding block
            x_d     = chain_mode_q ? ({PAD_FULL, PAD_FULL} ^ x_q) : {PAD_FULL, PAD_FULL};
            extra_d = 1'b0;
            last_d  = 1'b1;
            pad_d   = BLOCK_BYTES;
            cnt_d   = '0;
            state_d = ST_ROUND;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_KEYLD;
    endcase

    // new key: rerun the schedule
    if (key_wr) begin
      state_d = ST_KEYLD;
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_KEYLD;
      cnt_q       <= '0;
      chain_q     <= '0;
      last_q      <= 1'b0;
      pad_q       <= '0;
      extra_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      chain_q     <= chain_d;
      last_q      <= last_d;
      pad_q       <= pad_d;
      extra_q     <= extra_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    hold_q     <= hold_d;
    out_blk_q  <= out_blk_d;
    out_last_q <= out_last_d;
    out_pad_q  <= out_pad_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_high  = out_blk_q[127:64];
  assign out_o.out_low   = out_blk_q[63:0];
  assign out_o.last_out  = out_last_q;
  assign out_o.pad_count = out_pad_q;

endmodule

@@ src/sm4ce_round.sv @@
// ----------------------------------------------------------------------------
// sm4ce_round
// One SM4 round, shared by the key schedule and the data path.
// ----------------------------------------------------------------------------
module sm4ce_round (
  input  logic [127:0]          x_i,
  input  logic [31:0]           rk_i,
  input  sm4ce_pkg::rmode_e     mode_i,
  output logic [31:0]           t_o
);
  import sm4ce_pkg::*;

  logic [31:0] w0, w1, w2, w3;
  logic [31:0] mix, s;
  logic [31:0] l_data, l_key;

  assign w0 = x_i[127:96];
  assign w1 = x_i[95:64];
  assign w2 = x_i[63:32];
  assign w3 = x_i[31:0];

  assign mix = w1 ^ w2 ^ w3 ^ rk_i;
  assign s   = sbox_word(mix);

  assign l_data = s ^ {s[29:0], s[31:30]} ^ {s[21:0], s[31:22]}
                    ^ {s[13:0], s[31:14]} ^ {s[7:0], s[31:8]};
  assign l_key  = s ^ {s[18:0], s[31:19]} ^ {s[8:0], s[31:9]};

  assign t_o = w0 ^ ((mode_i == RM_KEY) ? l_key : l_data);

endmodule

@@ verif/sm4ce_cipher_check.sv @@
// ----------------------------------------------------------------------------
// sm4ce_cipher_check
// Watches the APB port and both block channels of the SM4 ECB/CBC cipher.
// Keeps its own copy of the key, IV, mode and chaining value, computes the
// result blocks of every accepted input block, and compares each returned
// block field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module sm4ce_cipher_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  sm4ce_in_if         blk_in,
  sm4ce_out_if        blk_out,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sm4ce_pkg::*;

  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        last;
    logic [7:0]  pad;
  } cipher_out_t;

  cipher_out_t  pending_blocks [$];
  logic [63:0]  key_hi_m = '0;
  logic [63:0]  key_lo_m = '0;
  logic [63:0]  iv_hi_m  = '0;
  logic [63:0]  iv_lo_m  = '0;
  logic         cbc_m    = 1'b0;
  logic         dec_m    = 1'b0;
  logic [127:0] chain_m  = '0;
  logic [31:0]  rk_m [ROUND_COUNT];
  int unsigned  n_fail   = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic logic [31:0] tau(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] w, input int n);
    return (w << n) | (w >> (32 - n));
  endfunction

  function automatic void expand_key();
    logic [31:0] k [4];
    logic [31:0] t;
    logic [31:0] ck;
    logic [7:0]  b;
    k[0] = key_hi_m[63:32] ^ FK0;
    k[1] = key_hi_m[31:0]  ^ FK1;
    k[2] = key_lo_m[63:32] ^ FK2;
    k[3] = key_lo_m[31:0]  ^ FK3;
    for (int i = 0; i < ROUND_COUNT; i++) begin
      ck = '0;
      for (int j = 0; j < 4; j++) begin
        b  = 8'(8'(4 * i + j) * CK_STEP);
        ck = {ck[23:0], b};
      end
      t = tau(k[1] ^ k[2] ^ k[3] ^ ck);
      t = k[0] ^ t ^ rotl(t, 13) ^ rotl(t, 23);
      k[0] = k[1];
      k[1] = k[2];
      k[2] = k[3];
      k[3] = t;
      rk_m[i] = t;
    end
  endfunction

  function automatic logic [127:0] sm4_rounds(input logic [127:0] blk, input logic inverse);
    logic [31:0] x [4];
    logic [31:0] t;
    logic [31:0] rk;
    x[0] = blk[127:96];
    x[1] = blk[95:64];
    x[2] = blk[63:32];
    x[3] = blk[31:0];
    for (int i = 0; i < ROUND_COUNT; i++) begin
      rk = inverse ? rk_m[ROUND_COUNT - 1 - i] : rk_m[i];
      t  = tau(x[1] ^ x[2] ^ x[3] ^ rk);
      t  = x[0] ^ t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
      x[0] = x[1];
      x[1] = x[2];
      x[2] = x[3];
      x[3] = t;
    end
    return {x[3], x[2], x[1], x[0]};
  endfunction

  // encrypt one block and advance the chain to the ciphertext
  function automatic void push_ciphertext(input logic [127:0] plain, input logic last,
                                          input logic [7:0] pad);
    logic [127:0] c;
    c = sm4_rounds(cbc_m ? (plain ^ chain_m) : plain, 1'b0);
    chain_m = c;
    pending_blocks.push_back('{hi: c[127:64], lo: c[63:0], last: last, pad: pad});
  endfunction

  function automatic void predict_blocks(input logic [127:0] blk, input logic first,
                                         input logic last, input logic [4:0] vb);
    logic [127:0] p;
    logic [4:0]   n;
    logic [7:0]   fill;
    n = (vb > BLOCK_BYTES) ? BLOCK_BYTES : vb;
    if (first) chain_m = {iv_hi_m, iv_lo_m};
    if (dec_m) begin
      p = sm4_rounds(blk, 1'b1);
      if (cbc_m) p = p ^ chain_m;
      chain_m = blk;
      pending_blocks.push_back('{hi: p[127:64], lo: p[63:0], last: last,
                                 pad: last ? p[7:0] : 8'h00});
    end else if (!last) begin
      push_ciphertext(blk, 1'b0, 8'h00);
    end else if (n == BLOCK_BYTES) begin
      // full tail: data block, then a block made only of padding
      push_ciphertext(blk, 1'b0, 8'h00);
      push_ciphertext({PAD_FULL, PAD_FULL}, 1'b1, 8'(BLOCK_BYTES));
    end else begin
      fill = 8'(BLOCK_BYTES - n);
      p    = blk;
      for (int i = 0; i < BLOCK_BYTES; i++) begin
        if (i >= n) p[127 - 8 * i -: 8] = fill;
      end
      push_ciphertext(p, 1'b1, fill);
    end
  endfunction

  function automatic void note_failure(input string what, input cipher_out_t want,
                                       input cipher_out_t got);
    n_fail++;
    if (n_fail <= REPORT_MAX) begin
      $display("%0t %s: expected hi=%h lo=%h last=%b pad=%h, got hi=%h lo=%h last=%b pad=%h",
               $realtime, what, want.hi, want.lo, want.last, want.pad,
               got.hi, got.lo, got.last, got.pad);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cipher_out_t got;
    cipher_out_t want;
    if (!rst_ni) begin
      key_hi_m = '0;
      key_lo_m = '0;
      iv_hi_m  = '0;
      iv_lo_m  = '0;
      cbc_m    = 1'b0;
      dec_m    = 1'b0;
      chain_m  = '0;
      expand_key();
      pending_blocks.delete();
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_KEY_HI: begin
            key_hi_m = pwdata;
            expand_key();
          end
          REG_KEY_LO: begin
            key_lo_m = pwdata;
            expand_key();
          end
          REG_IV_HI: iv_hi_m = pwdata;
          REG_IV_LO: iv_lo_m = pwdata;
          REG_CHAIN: cbc_m   = pwdata[0];
          REG_DIR:   dec_m   = pwdata[0];
          default: ;
        endcase
      end
      if (blk_out.valid && blk_out.ready) begin
        got = '{hi: blk_out.out_high, lo: blk_out.out_low, last: blk_out.last_out,
                pad: blk_out.pad_count};
        if (pending_blocks.size() == 0) begin
          note_failure("unexpected result", '0, got);
        end else begin
          want = pending_blocks.pop_front();
          if (got.hi !== want.hi || got.lo !== want.lo || got.last !== want.last ||
              got.pad !== want.pad) begin
            note_failure("result mismatch", want, got);
          end
        end
      end
      if (blk_in.valid && blk_in.ready) begin
        predict_blocks({blk_in.block_high, blk_in.block_low}, blk_in.first_block,
                       blk_in.last_block, blk_in.valid_bytes);
      end
      pending_o <= pending_blocks.size();
    end
    fail_count_o <= n_fail;
  end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the SM4 ECB/CBC cipher.
// Programs key, IV, mode and direction over APB once no results are pending,
// runs a directed set of padding and chaining corner cases, then random
// messages with random stalls on both channels. Checking is done by
// sm4ce_cipher_check; a watchdog ends the run if transfers stop.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sm4ce_pkg::*;

  localparam int unsigned BLOCKS_TOTAL = 1750;
  localparam int unsigned CALM_TAIL    = 150;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 80;

  localparam logic MODE_ECB = 1'b0;
  localparam logic MODE_CBC = 1'b1;
  localparam logic DIR_ENC  = 1'b0;
  localparam logic DIR_DEC  = 1'b1;

  localparam logic [63:0] SAMPLE_HI = 64'h0123_4567_89ab_cdef;
  localparam logic [63:0] SAMPLE_LO = 64'hfedc_ba98_7654_3210;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned sent  = 0;
  int unsigned quiet = 0;
  bit          calm  = 1'b0;

  sm4ce_in_if  in_if ();
  sm4ce_out_if out_if ();

  sm4_cipher_ecb_cbc dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_if),
    .out_o   (out_if)
  );

  sm4ce_cipher_check chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .blk_in       (in_if),
    .blk_out      (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (psel && penable)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic logic [63:0] pick64();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [4:0] pick_tail_bytes();
    if ($urandom_range(0, 7) == 0) return 5'($urandom_range(17, 31));
    return 5'($urandom_range(0, 16));
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic apb_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_block(input logic [127:0] blk, input logic first, input logic last,
                            input logic [4:0] vb);
    int unsigned gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap != 0) begin
      // drop valid and put junk on the payload meanwhile
      in_if.valid       <= 1'b0;
      in_if.block_high  <= {$urandom, $urandom};
      in_if.block_low   <= {$urandom, $urandom};
      in_if.first_block <= 1'($urandom);
      in_if.last_block  <= 1'($urandom);
      in_if.valid_bytes <= 5'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.block_high  <= blk[127:64];
    in_if.block_low   <= blk[63:0];
    in_if.first_block <= first;
    in_if.last_block  <= last;
    in_if.valid_bytes <= vb;
    do @(posedge clk_i); while (!in_if.ready);
    sent++;
    calm = (sent + CALM_TAIL >= BLOCKS_TOTAL);
  endtask

  task automatic wait_drained(input int unsigned extra);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // result side: random stall bursts, none in the calm tail
  initial begin : result_sink
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    int unsigned quota;
    int unsigned len;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    in_if.valid       <= 1'b0;
    in_if.block_high  <= '0;
    in_if.block_low   <= '0;
    in_if.first_block <= 1'b0;
    in_if.last_block  <= 1'b0;
    in_if.valid_bytes <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // CBC before any first block: chain starts from the reset zero
    write_reg(REG_KEY_HI, SAMPLE_HI);
    write_reg(REG_KEY_LO, SAMPLE_LO);
    write_reg(REG_CHAIN, 64'(MODE_CBC));
    apb_release();
    send_block({SAMPLE_HI, SAMPLE_LO}, 1'b0, 1'b0, BLOCK_BYTES);
    send_block('0, 1'b0, 1'b0, 5'd0);
    send_block('1, 1'b0, 1'b1, 5'd1);
    wait_drained(4);

    // CBC encrypt: chained message, full tail, empty message, short tails, an over-range byte count
    write_reg(REG_IV_HI, {$urandom, $urandom});
    write_reg(REG_IV_LO, {$urandom, $urandom});
    write_reg(REG_DIR, 64'(DIR_ENC));
    apb_release();
    send_block({pick64(), pick64()}, 1'b1, 1'b0, BLOCK_BYTES);
    send_block({pick64(), pick64()}, 1'b0, 1'b0, BLOCK_BYTES);
    send_block({pick64(), pick64()}, 1'b0, 1'b1, BLOCK_BYTES);
    send_block({pick64(), pick64()}, 1'b1, 1'b1, 5'd0);
    send_block({pick64(), pick64()}, 1'b1, 1'b1, 5'd15);
    send_block({pick64(), pick64()}, 1'b1, 1'b1, 5'd31);
    send_block({pick64(), pick64()}, 1'b1, 1'b1, 5'd8);
    wait_drained(4);

    write_reg(REG_CHAIN, 64'(MODE_ECB));
    apb_release();
    send_block('1, 1'b0, 1'b0, BLOCK_BYTES);
    send_block({pick64(), pick64()}, 1'b0, 1'b1, 5'd17);
    send_block({pick64(), pick64()}, 1'b0, 1'b1, 5'd0);
    wait_drained(4);

    write_reg(REG_DIR, 64'(DIR_DEC));
    apb_release();
    send_block({pick64(), pick64()}, 1'b0, 1'b0, BLOCK_BYTES);
    send_block('1, 1'b0, 1'b1, BLOCK_BYTES);
    send_block('0, 1'b0, 1'b1, 5'd0);
    wait_drained(4);

    write_reg(REG_CHAIN, 64'(MODE_CBC));
    write_reg(REG_KEY_HI, '1);
    write_reg(REG_KEY_LO, '0);
    apb_release();
    send_block({pick64(), pick64()}, 1'b1, 1'b0, BLOCK_BYTES);
    send_block({pick64(), pick64()}, 1'b0, 1'b0, BLOCK_BYTES);
    send_block({pick64(), pick64()}, 1'b0, 1'b1, BLOCK_BYTES);
    send_block({pick64(), pick64()}, 1'b1, 1'b1, 5'd5);
    wait_drained(4);

    write_reg(REG_KEY_HI, '0);
    write_reg(REG_IV_HI, '1);
    write_reg(REG_IV_LO, '1);
    write_reg(REG_DIR, 64'(DIR_ENC));
    apb_release();
    send_block('1, 1'b1, 1'b1, BLOCK_BYTES);
    send_block({pick64(), pick64()}, 1'b1, 1'b1, 5'd1);

    // random phases: new settings, then mostly well-formed messages
    while (sent < BLOCKS_TOTAL) begin
      wait_drained(4);
      if ($urandom_range(0, 3) == 0) write_reg(REG_KEY_HI, pick64());
      if ($urandom_range(0, 3) == 0) write_reg(REG_KEY_LO, pick64());
      if ($urandom_range(0, 2) == 0) write_reg(REG_IV_HI, pick64());
      if ($urandom_range(0, 2) == 0) write_reg(REG_IV_LO, pick64());
      if ($urandom_range(0, 1) == 0) write_reg(REG_CHAIN, 64'($urandom_range(0, 1)));
      if ($urandom_range(0, 1) == 0) write_reg(REG_DIR, 64'($urandom_range(0, 1)));
      apb_release();
      quota = sent + $urandom_range(30, 90);
      while (sent < quota && sent < BLOCKS_TOTAL) begin
        if ($urandom_range(0, 6) == 0) begin
          send_block({pick64(), pick64()}, 1'($urandom), 1'($urandom), 5'($urandom));
        end else begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
          for (int k = 0; k < len; k++) begin
            send_block({pick64(), pick64()}, k == 0, k == len - 1,
                       (k == len - 1) ? pick_tail_bytes() : BLOCK_BYTES);
          end
        end
      end
    end

    wait_drained(DRAIN_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
